@@ sv/mahs_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the moving average hysteresis switch
// no dependencies

package mahs_pkg;

	localparam int unsigned WINDOW_DEF = 5;
	localparam int unsigned DATA_W     = 12;
	localparam int unsigned ADDR_W     = 3;
	localparam int unsigned PDATA_W    = 32;

	localparam logic [DATA_W-1:0] LOW_RESET  = 12'd1200;
	localparam logic [DATA_W-1:0] HIGH_RESET = 12'd1800;

	// register select, taken from paddr[2]
	localparam logic REG_LOW  = 1'b0;
	localparam logic REG_HIGH = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] low;
		logic [DATA_W-1:0] high;
	} thresh_t;

endpackage

@@ sv/mahs_if.sv @@
`timescale 1ns / 1ps
// valid/ready channels for samples and results
// depends on mahs_pkg

interface mahs_sample_if;
	logic                         valid;
	logic                         ready;
	logic [mahs_pkg::DATA_W-1:0]  sample_mv;

	modport source (output valid, output sample_mv, input ready);
	modport sink   (input valid, input sample_mv, output ready);
endinterface

interface mahs_result_if;
	logic                         valid;
	logic                         ready;
	logic [mahs_pkg::DATA_W-1:0]  average_mv;
	logic                         switch_on;

	modport source (output valid, output average_mv, output switch_on, input ready);
	modport sink   (input valid, input average_mv, input switch_on, output ready);
endinterface

@@ sv/mahs_cell.sv @@
`timescale 1ns / 1ps
// one window cell: holds a sample and hands it to the next cell on each transfer
// depends on mahs_pkg

module mahs_cell (
	input  logic                        clk,
	input  logic                        shift,
	input  logic                        fill,
	input  logic [mahs_pkg::DATA_W-1:0] sample,
	input  logic [mahs_pkg::DATA_W-1:0] prev,
	output logic [mahs_pkg::DATA_W-1:0] value
);

	logic [mahs_pkg::DATA_W-1:0] value_q;

	// fill loads every cell with the same sample, otherwise take the neighbour
	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= fill ? sample : prev;
		end
	end

	assign value = value_q;

endmodule

@@ sv/mahs_regs.sv @@
`timescale 1ns / 1ps
// apb threshold registers
// depends on mahs_pkg

module mahs_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mahs_pkg::ADDR_W-1:0]  paddr,
	input  logic [mahs_pkg::PDATA_W-1:0] pwdata,
	output logic [mahs_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output mahs_pkg::thresh_t            thresh
);

	mahs_pkg::thresh_t thresh_q;
	logic              wr_en;

	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q.low  <= mahs_pkg::LOW_RESET;
			thresh_q.high <= mahs_pkg::HIGH_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				mahs_pkg::REG_LOW: begin
					thresh_q.low <= pwdata[mahs_pkg::DATA_W-1:0];
				end
				mahs_pkg::REG_HIGH: begin
					thresh_q.high <= pwdata[mahs_pkg::DATA_W-1:0];
				end
				default: begin
					thresh_q <= thresh_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			mahs_pkg::REG_LOW: begin
				prdata = {{(mahs_pkg::PDATA_W-mahs_pkg::DATA_W){1'b0}}, thresh_q.low};
			end
			mahs_pkg::REG_HIGH: begin
				prdata = {{(mahs_pkg::PDATA_W-mahs_pkg::DATA_W){1'b0}}, thresh_q.high};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign thresh = thresh_q;

endmodule

@@ sv/moving_average_hysteresis_switch_unit.sv @@
`timescale 1ns / 1ps
// top level of the moving average hysteresis switch
// depends on mahs_pkg, mahs_if, mahs_cell, mahs_regs
//
// channel   dir   handshake      payload
// samples   in    valid/ready    sample_mv[11:0]
// results   out   valid/ready    average_mv[11:0], switch_on
// apb       in    psel/penable   low_threshold @0x0, high_threshold @0x4
//
// one sample per cycle while no stage stalls; s1, s2 and the output register lie between transfer in and result shown
// stages: running sum (s1), reciprocal multiply (s2), hysteresis and output register
// each stage has its own valid and stalls only when the stage ahead is full
// arst_n clears the sum, primed flag, valids and switch; cells hold data only
// the first sample after reset fills every cell of the chain

module moving_average_hysteresis_switch_unit #(
	parameter int unsigned WINDOW = mahs_pkg::WINDOW_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	mahs_sample_if.sink                  samples,
	mahs_result_if.source                results,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mahs_pkg::ADDR_W-1:0]  paddr,
	input  logic [mahs_pkg::PDATA_W-1:0] pwdata,
	output logic [mahs_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	localparam int unsigned DW      = mahs_pkg::DATA_W;
	// sum is wide enough for WINDOW full-scale samples
	localparam int unsigned SUM_W   = $clog2(WINDOW * 4095 + 1);
	localparam int unsigned LOG_W   = $clog2(WINDOW);
	// floor(x / WINDOW) == (x * RECIP) >> SHIFT for every x below 2**SUM_W
	localparam int unsigned SHIFT   = SUM_W + LOG_W;
	localparam int unsigned RECIP_W = SUM_W + 2;
	localparam int unsigned PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << SHIFT) / 64'(WINDOW) + 64'd1);

	mahs_pkg::thresh_t thresh;

	// handshake and stage control
	logic in_xfer;
	logic rdy_out, rdy_s2, rdy_s1;
	logic valid_s1, valid_s2, out_valid_q;

	// window chain and running sum
	logic [DW-1:0]    chain [WINDOW];
	logic             primed_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W:0]   sum_ext;
	logic [SUM_W-1:0] sum_next;

	logic [SUM_W-1:0]  sum_s1;
	logic [PROD_W-1:0] prod;
	logic [DW-1:0]     quot_s2;
	logic [DW-1:0]     avg_q;
	logic              sw_q;
	logic              sw_next;

	mahs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.thresh  (thresh)
	);

	// a stage may load when it is empty or its content moves on this cycle
	assign rdy_out = !out_valid_q || results.ready;
	assign rdy_s2  = !valid_s2 || rdy_out;
	assign rdy_s1  = !valid_s1 || rdy_s2;
	assign samples.ready = rdy_s1;
	assign in_xfer = samples.valid && rdy_s1;

	// cell chain: cell 0 takes the new sample, the last cell holds the oldest one
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			mahs_cell u_cell (
				.clk    (clk),
				.shift  (in_xfer),
				.fill   (!primed_q),
				.sample (samples.sample_mv),
				.prev   (samples.sample_mv),
				.value  (chain[i])
			);
		end else begin : g_body
			mahs_cell u_cell (
				.clk    (clk),
				.shift  (in_xfer),
				.fill   (!primed_q),
				.sample (samples.sample_mv),
				.prev   (chain[i-1]),
				.value  (chain[i])
			);
		end
	end

	// oldest sample leaves the sum as the new one enters; never goes negative
	assign sum_ext = {1'b0, sum_q} - (SUM_W+1)'(chain[WINDOW-1])
		+ (SUM_W+1)'(samples.sample_mv);
	assign sum_next = primed_q ? sum_ext[SUM_W-1:0]
		: SUM_W'(32'(samples.sample_mv) * 32'(WINDOW));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			sum_q    <= '0;
		end else if (in_xfer) begin
			primed_q <= 1'b1;
			sum_q    <= sum_next;
		end
	end

	// stage 1: snapshot of the sum after this sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sum_s1 <= sum_next;
		end
	end

	// stage 2: divide by the window length through the reciprocal
	assign prod = PROD_W'(sum_s1) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			quot_s2 <= prod[SHIFT +: DW];
		end
	end

	// hysteresis: turn-on test first, so it wins when thresholds cross
	always_comb begin
		sw_next = sw_q;
		if (quot_s2 < thresh.low) begin
			sw_next = 1'b1;
		end else if (quot_s2 > thresh.high) begin
			sw_next = 1'b0;
		end
	end

	// output register, also the latched switch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sw_q        <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= valid_s2;
			if (valid_s2) begin
				sw_q <= sw_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && valid_s2) begin
			avg_q <= quot_s2;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.average_mv = avg_q;
	assign results.switch_on  = sw_q;

endmodule

@@ sv/mahs_checker.sv @@
`timescale 1ns / 1ps
// port-level checks of the moving average hysteresis switch, bound to the top level
// depends on mahs_pkg and moving_average_hysteresis_switch_unit

module mahs_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [mahs_pkg::DATA_W-1:0]  in_sample,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [mahs_pkg::DATA_W-1:0]  out_average,
	input  logic                         out_switch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mahs_pkg::ADDR_W-1:0]  paddr,
	input  logic [mahs_pkg::PDATA_W-1:0] pwdata
);

	logic                        in_xfer, out_xfer, wr_en;
	logic [2:0]                  inflight_q;
	logic                        first_seen_q, first_out_q;
	logic [mahs_pkg::DATA_W-1:0] first_val_q;
	mahs_pkg::thresh_t           thresh_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign wr_en    = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q   <= '0;
			first_seen_q <= 1'b0;
			first_out_q  <= 1'b0;
			first_val_q  <= '0;
			thresh_q.low  <= mahs_pkg::LOW_RESET;
			thresh_q.high <= mahs_pkg::HIGH_RESET;
		end else begin
			inflight_q <= inflight_q + 3'(in_xfer) - 3'(out_xfer);
			if (in_xfer && !first_seen_q) begin
				first_seen_q <= 1'b1;
				first_val_q  <= in_sample;
			end
			if (out_xfer) begin
				first_out_q <= 1'b1;
			end
			if (wr_en) begin
				if (paddr[2] == mahs_pkg::REG_HIGH) begin
					thresh_q.high <= pwdata[mahs_pkg::DATA_W-1:0];
				end else begin
					thresh_q.low <= pwdata[mahs_pkg::DATA_W-1:0];
				end
			end
		end
	end

	// a stalled result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_average) && $stable(out_switch))
		else $error("result changed while stalled");

	// no result without a sample in flight, never more than three in flight
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid |-> inflight_q != 3'd0) and (inflight_q <= 3'd3))
		else $error("result count out of step with samples");

	// the first result after reset repeats the first sample
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !first_out_q |-> first_seen_q && out_average == first_val_q)
		else $error("first average differs from first sample");

	// switch follows the thresholds
	a_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_average < thresh_q.low |-> out_switch)
		else $error("switch off below low threshold");

	a_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_average >= thresh_q.low && out_average > thresh_q.high |-> !out_switch)
		else $error("switch on above high threshold");

endmodule

bind moving_average_hysteresis_switch_unit mahs_checker u_mahs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.in_sample   (samples.sample_mv),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_average (results.average_mv),
	.out_switch  (results.switch_on),
	.psel        (psel),
	.penable     (penable),
	.pwrite      (pwrite),
	.paddr       (paddr),
	.pwdata      (pwdata)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the moving average hysteresis switch unit
// depends on mahs_pkg, mahs_if and moving_average_hysteresis_switch_unit

module testbench;
	import mahs_pkg::*;

	localparam int unsigned WIN              = WINDOW_DEF;
	localparam int unsigned MAX_REPORTED     = 10;
	localparam int unsigned RANDOM_PER_PHASE = 135;
	localparam int unsigned PHASES           = 8;
	localparam int unsigned HOLD_CYCLES      = 80;
	// pipeline is three stages deep, and the settle below drains it
	localparam int unsigned SETTLE_CYCLES    = 8;
	// longest legal quiet spell is the long receiver hold plus a settle
	localparam int unsigned WATCHDOG_LIMIT   = 2000;

	// one expected transfer on the result channel
	typedef struct packed {
		logic [DATA_W-1:0] average_mv;
		logic              switch_on;
	} reading_t;

	// mirrors the averaging window and the latched switch, and holds the
	// readings that the block still owes us
	class avg_scoreboard;
		logic [DATA_W-1:0] ring [WIN];
		int unsigned       total;
		int unsigned       wr_idx;
		bit                primed;
		bit                sw;
		logic [DATA_W-1:0] low_thr;
		logic [DATA_W-1:0] high_thr;
		reading_t          pending [$];
		int unsigned       compared;
		int unsigned       failures;
		int unsigned       toggles;

		function new();
			total    = 0;
			wr_idx   = 0;
			primed   = 1'b0;
			sw       = 1'b0;
			low_thr  = LOW_RESET;
			high_thr = HIGH_RESET;
			compared = 0;
			failures = 0;
			toggles  = 0;
			foreach (ring[i]) ring[i] = '0;
		endfunction

		// bits above the field width are dropped on write
		function void set_threshold(logic sel, logic [PDATA_W-1:0] word);
			if (sel == REG_LOW) begin
				low_thr = word[DATA_W-1:0];
			end else begin
				high_thr = word[DATA_W-1:0];
			end
		endfunction

		function void note_sample(logic [DATA_W-1:0] mv);
			int unsigned avg;
			bit          was;
			reading_t    want;
			was = sw;
			if (!primed) begin
				// first sample after reset fills the whole window
				foreach (ring[i]) ring[i] = mv;
				total  = 32'(mv) * WIN;
				wr_idx = 0;
				primed = 1'b1;
				avg    = 32'(mv);
			end else begin
				total = total - 32'(ring[wr_idx]) + 32'(mv);
				ring[wr_idx] = mv;
				wr_idx = (wr_idx + 1 == WIN) ? 0 : wr_idx + 1;
				avg = total / WIN;
			end
			// turn-on test first, so it wins when the thresholds cross
			if (avg < low_thr) begin
				sw = 1'b1;
			end else if (avg > high_thr) begin
				sw = 1'b0;
			end
			if (sw != was) toggles++;
			want.average_mv = avg[DATA_W-1:0];
			want.switch_on  = sw;
			pending.push_back(want);
		endfunction

		function void check_result(logic [DATA_W-1:0] avg, logic on);
			reading_t want;
			if (pending.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTED)
					$display("unexpected result: average %0d switch %0b", avg, on);
			end else begin
				want = pending.pop_front();
				compared++;
				if (want.average_mv !== avg || want.switch_on !== on) begin
					failures++;
					if (failures <= MAX_REPORTED)
						$display({"mismatch on result %0d: expected average %0d switch %0b,",
							" got average %0d switch %0b"},
							compared, want.average_mv, want.switch_on, avg, on);
				end
			end
		endfunction
	endclass

	// directed opening: first sample primes the window, then the average is
	// dragged down past the low threshold, held in the band, and pushed just
	// past the high threshold; alternating bit patterns close it off
	localparam logic [DATA_W-1:0] DIRECTED [24] = '{
		12'd2000, 12'd4095, 12'd0,    12'd0,    12'd0,    12'd0,
		12'd0,    12'd1200, 12'd1200, 12'd1200, 12'd1200, 12'd1200,
		12'd1800, 12'd1800, 12'd1800, 12'd1800, 12'd1800, 12'd1801,
		12'd1801, 12'd1801, 12'd1801, 12'd1801, 12'hAAA,  12'h555
	};

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	mahs_sample_if samples_ch ();
	mahs_result_if results_ch ();

	avg_scoreboard sb = new();

	// idling switches per phase, and the one-off long receiver hold
	bit          tx_idle;
	bit          rx_idle;
	bit          hold_request;
	int unsigned sent;
	int unsigned idle_cycles;
	int unsigned settings_used;

	// burst generator state: runs of samples around a chosen level
	int          level;
	int unsigned run_left;

	moving_average_hysteresis_switch_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog: any quiet spell this long means the block has hung
	always @(posedge clk) begin
		if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// mostly runs near a threshold so the average wanders across the
	// hysteresis band, with some full-range levels, rail levels and noise
	function automatic logic [DATA_W-1:0] next_sample();
		int v;
		if (run_left == 0) begin
			run_left = $urandom_range(1, 8);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					level = int'($urandom_range(0, 4095));
				end
				3, 4, 5: begin
					level = int'(sb.low_thr) + int'($urandom_range(0, 400)) - 200;
				end
				6, 7, 8: begin
					level = int'(sb.high_thr) + int'($urandom_range(0, 400)) - 200;
				end
				default: begin
					level = ($urandom_range(0, 1) != 0) ? 4095 : 0;
				end
			endcase
		end
		run_left--;
		if ($urandom_range(0, 7) == 0) begin
			v = int'($urandom_range(0, 4095));
		end else begin
			v = level + int'($urandom_range(0, 64)) - 32;
		end
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return v[DATA_W-1:0];
	endfunction

	// offers one sample and returns at the edge of its transfer; valid stays
	// high so a back-to-back sample follows with no bubble
	task automatic send_sample(input logic [DATA_W-1:0] mv);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_ch.valid     <= 1'b1;
		samples_ch.sample_mv <= mv;
		do @(posedge clk); while (!samples_ch.ready);
		sb.note_sample(mv);
		sent++;
	endtask

	// apb write: setup cycle, then access until pready; junk in the upper
	// bits of pwdata must be ignored
	task automatic write_register(input logic sel, input logic [DATA_W-1:0] value);
		logic [PDATA_W-1:0] word;
		word = $urandom();
		word[DATA_W-1:0] = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_threshold(sel, word);
	endtask

	// let every owed reading arrive, then give the pipeline time to empty
	task automatic settle();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side: random ready gaps, plus one long hold on request so the
	// pipeline backs up into the sample channel
	initial begin
		int unsigned gap;
		results_ch.ready = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				results_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = rx_idle ? $urandom_range(0, 4) : 0;
			if (gap != 0) begin
				results_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			results_ch.ready <= 1'b1;
			do @(posedge clk); while (!results_ch.valid);
			sb.check_result(results_ch.average_mv, results_ch.switch_on);
		end
	end

	initial begin
		int unsigned       ph;
		int unsigned       n;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;

		arst_n               = 1'b0;
		samples_ch.valid     = 1'b0;
		samples_ch.sample_mv = '0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		tx_idle              = 1'b0;
		rx_idle              = 1'b0;
		hold_request         = 1'b0;
		sent                 = 0;
		idle_cycles          = 0;
		settings_used        = 1;
		run_left             = 0;
		level                = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass under the reset thresholds, no idling
		foreach (DIRECTED[i]) send_sample(DIRECTED[i]);
		samples_ch.valid <= 1'b0;
		settle();

		for (ph = 1; ph <= PHASES; ph++) begin
			case (ph)
				1: begin
					// widest band: the switch can never move
					lo = 12'd0;    hi = 12'd4095; tx_idle = 1'b1; rx_idle = 1'b1;
				end
				2: begin
					// crossed at the extremes: turn-on wins for every average below 4095
					lo = 12'd4095; hi = 12'd0;    tx_idle = 1'b1; rx_idle = 1'b0;
				end
				3: begin
					// crossed band, sink stalls and one long hold-off
					lo = 12'd3000; hi = 12'd1000; tx_idle = 1'b0; rx_idle = 1'b1;
					hold_request = 1'b1;
				end
				4: begin
					// default band at full rate both ways
					lo = 12'd1200; hi = 12'd1800; tx_idle = 1'b0; rx_idle = 1'b0;
				end
				default: begin
					lo = DATA_W'($urandom_range(0, 4095));
					hi = DATA_W'($urandom_range(0, 4095));
					tx_idle = 1'($urandom_range(0, 1));
					rx_idle = 1'($urandom_range(0, 1));
				end
			endcase
			write_register(REG_LOW, lo);
			write_register(REG_HIGH, hi);
			settings_used++;
			for (n = 0; n < RANDOM_PER_PHASE; n++) send_sample(next_sample());
			samples_ch.valid <= 1'b0;
			settle();
		end

		$display("%0d samples over %0d threshold settings, %0d results compared",
			sent, settings_used, sb.compared);
		$display("switch changed state %0d times, including crossed and extreme bands",
			sb.toggles);
		if (sb.failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d failures", sb.failures);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
